>>> src/qst_vertex_transform_macros.svh
// assertion macros for the vertex transform
`ifndef QST_VERTEX_TRANSFORM_MACROS_SVH
`define QST_VERTEX_TRANSFORM_MACROS_SVH

// same-cycle implication, off while in reset
`define QST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while in reset
`define QST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/qst_pkg.sv
// shared types and constants for the vertex transform
package qst_pkg;

  localparam int COORD_W    = 32;
  localparam int QUAT_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int QUAT_FRAC  = 14;
  localparam int SCALE_FRAC = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_QUAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_XYZ     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_Z   = 3'd4;

  localparam logic [63:0] ROTATION_RESET = 64'h4000_0000_0000_0000;
  localparam logic [47:0] SCALE_RESET    = 48'h0100_0100_0100;

  // scaled coordinate
  localparam int PROD_W = COORD_W + SCALE_W;
  localparam int S_W    = PROD_W + 1 - SCALE_FRAC;
  // cross product q x s
  localparam int QS_W   = QUAT_W + S_W;
  localparam int CD_W   = QS_W + 1;
  localparam int C_W    = CD_W + 1 - QUAT_FRAC;
  localparam int T_W    = C_W + 1;
  // rotation terms
  localparam int QT_W   = QUAT_W + T_W;
  localparam int E_W    = QT_W + 3;
  localparam int R_W    = E_W - QUAT_FRAC + 1;
  // after translation
  localparam int F_W    = R_W + 1;

  localparam int SCALE_HALF = 1 << (SCALE_FRAC - 1);
  localparam int QUAT_HALF  = 1 << (QUAT_FRAC - 1);

  typedef struct packed {
    logic signed [QUAT_W-1:0]  qw;
    logic signed [QUAT_W-1:0]  qx;
    logic signed [QUAT_W-1:0]  qy;
    logic signed [QUAT_W-1:0]  qz;
    logic signed [SCALE_W-1:0] kx;
    logic signed [SCALE_W-1:0] ky;
    logic signed [SCALE_W-1:0] kz;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic signed [COORD_W-1:0] tz;
  } cfg_t;

  typedef struct packed {
    logic                  op;
    logic signed [S_W-1:0] x;
    logic signed [S_W-1:0] y;
    logic signed [S_W-1:0] z;
  } scaled_t;

  typedef struct packed {
    logic                  op;
    logic signed [R_W-1:0] x;
    logic signed [R_W-1:0] y;
    logic signed [R_W-1:0] z;
  } rotated_t;

endpackage

>>> src/qst_in_if.sv
// vertex input channel
interface qst_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [qst_pkg::COORD_W-1:0] in_x;
  logic signed [qst_pkg::COORD_W-1:0] in_y;
  logic signed [qst_pkg::COORD_W-1:0] in_z;

  modport source (output valid, op, in_x, in_y, in_z, input ready);
  modport sink (input valid, op, in_x, in_y, in_z, output ready);
endinterface

>>> src/qst_out_if.sv
// vertex result channel
interface qst_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qst_pkg::COORD_W-1:0] out_x;
  logic signed [qst_pkg::COORD_W-1:0] out_y;
  logic signed [qst_pkg::COORD_W-1:0] out_z;
  logic                                saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

>>> src/qst_vertex_transform.sv
// top level of the quaternion scale translate vertex transform
//
//  channel    dir  transaction
//  vtx_in     in   op, in_x, in_y, in_z (valid/ready)
//  vtx_out    out  out_x, out_y, out_z, saturated (valid/ready)
//  cfg_*      in   register index and data, written when cfg_we is high
//
// one vertex per cycle while vtx_out is not stalled
// seven register stages: two scale, four rotate, one translate and clamp
// each stage holds while the next is full and stalled, bubbles close up
// synchronous reset clears valid bits and loads identity configuration
`include "qst_vertex_transform_macros.svh"

module qst_vertex_transform (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qst_pkg::CFG_DATA_W-1:0]    cfg_data,
  qst_in_if.sink                            vtx_in,
  qst_out_if.source                         vtx_out
);
  logic [63:0]              rotation_quat;
  logic [47:0]              scale_xyz;
  logic [qst_pkg::COORD_W-1:0] translate_x, translate_y, translate_z;
  qst_pkg::cfg_t            cfg;
  logic                     sc_valid, sc_ready;
  qst_pkg::scaled_t         sc_data;
  logic                     rt_valid, rt_ready;
  qst_pkg::rotated_t        rt_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_quat <= qst_pkg::ROTATION_RESET;
      scale_xyz     <= qst_pkg::SCALE_RESET;
      translate_x   <= '0;
      translate_y   <= '0;
      translate_z   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qst_pkg::REG_ROTATION_QUAT: rotation_quat <= cfg_data[63:0];
        qst_pkg::REG_SCALE_XYZ:     scale_xyz     <= cfg_data[47:0];
        qst_pkg::REG_TRANSLATE_X:   translate_x   <= cfg_data[31:0];
        qst_pkg::REG_TRANSLATE_Y:   translate_y   <= cfg_data[31:0];
        qst_pkg::REG_TRANSLATE_Z:   translate_z   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg.qw = $signed(rotation_quat[63:48]);
  assign cfg.qx = $signed(rotation_quat[47:32]);
  assign cfg.qy = $signed(rotation_quat[31:16]);
  assign cfg.qz = $signed(rotation_quat[15:0]);
  assign cfg.kx = $signed(scale_xyz[47:32]);
  assign cfg.ky = $signed(scale_xyz[31:16]);
  assign cfg.kz = $signed(scale_xyz[15:0]);
  assign cfg.tx = $signed(translate_x);
  assign cfg.ty = $signed(translate_y);
  assign cfg.tz = $signed(translate_z);

  qst_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (vtx_in.valid),
    .up_ready (vtx_in.ready),
    .up_op    (vtx_in.op),
    .up_x     (vtx_in.in_x),
    .up_y     (vtx_in.in_y),
    .up_z     (vtx_in.in_z),
    .dn_valid (sc_valid),
    .dn_ready (sc_ready),
    .dn_data  (sc_data)
  );

  qst_rotate u_rotate (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (sc_valid),
    .up_ready (sc_ready),
    .up_data  (sc_data),
    .dn_valid (rt_valid),
    .dn_ready (rt_ready),
    .dn_data  (rt_data)
  );

  qst_place u_place (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (rt_valid),
    .up_ready (rt_ready),
    .up_data  (rt_data),
    .dn       (vtx_out)
  );

  // a clamped result sits on a rail
  `QST_ASSERT_NOW(a_sat_rail, clk, rst, vtx_out.valid && vtx_out.saturated,
    vtx_out.out_x == 32'sh7fffffff || vtx_out.out_x == 32'sh80000000 ||
    vtx_out.out_y == 32'sh7fffffff || vtx_out.out_y == 32'sh80000000 ||
    vtx_out.out_z == 32'sh7fffffff || vtx_out.out_z == 32'sh80000000)

  // input stalls only when the whole pipe is backed up by the output
  `QST_ASSERT_NOW(a_stall_cause, clk, rst, !vtx_in.ready,
    vtx_out.valid && !vtx_out.ready && sc_valid && rt_valid)

  // nothing comes out right after reset
  `QST_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !vtx_out.valid && !sc_valid && !rt_valid)
endmodule

>>> src/qst_scale.sv
// per-axis scaling, two pipeline stages
module qst_scale (
  input  logic                                clk,
  input  logic                                rst,
  input  qst_pkg::cfg_t                       cfg,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic                                up_op,
  input  logic signed [qst_pkg::COORD_W-1:0] up_x,
  input  logic signed [qst_pkg::COORD_W-1:0] up_y,
  input  logic signed [qst_pkg::COORD_W-1:0] up_z,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output qst_pkg::scaled_t                    dn_data
);
  localparam int PW = qst_pkg::PROD_W;
  localparam int FR = qst_pkg::SCALE_FRAC;

  logic                 v1;
  logic                 op1;
  logic signed [PW-1:0] px, py, pz;
  logic                 en1, en2;
  logic        [PW:0]   rx, ry, rz;

  assign en2      = !dn_valid || dn_ready;
  assign en1      = !v1 || en2;
  assign up_ready = en1;

  assign rx = (PW+1)'(px) + (PW+1)'(qst_pkg::SCALE_HALF);
  assign ry = (PW+1)'(py) + (PW+1)'(qst_pkg::SCALE_HALF);
  assign rz = (PW+1)'(pz) + (PW+1)'(qst_pkg::SCALE_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) dn_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1 <= up_op;
      px  <= PW'(up_x) * PW'(cfg.kx);
      py  <= PW'(up_y) * PW'(cfg.ky);
      pz  <= PW'(up_z) * PW'(cfg.kz);
    end
    if (en2) begin
      dn_data.op <= op1;
      dn_data.x  <= $signed(rx[PW:FR]);
      dn_data.y  <= $signed(ry[PW:FR]);
      dn_data.z  <= $signed(rz[PW:FR]);
    end
  end
endmodule

>>> src/qst_rotate.sv
// quaternion rotation, four pipeline stages
module qst_rotate (
  input  logic              clk,
  input  logic              rst,
  input  qst_pkg::cfg_t     cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  qst_pkg::scaled_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output qst_pkg::rotated_t dn_data
);
  localparam int QS = qst_pkg::QS_W;
  localparam int CD = qst_pkg::CD_W;
  localparam int TW = qst_pkg::T_W;
  localparam int QT = qst_pkg::QT_W;
  localparam int EW = qst_pkg::E_W;
  localparam int RW = qst_pkg::R_W;
  localparam int FR = qst_pkg::QUAT_FRAC;

  logic                       va, vb, vc;
  logic                       ena, enb, enc, end_s;
  qst_pkg::scaled_t           sa, sb, sc;
  logic signed [QS-1:0]       m_ysz, m_zsy, m_zsx, m_xsz, m_xsy, m_ysx;
  logic signed [TW-1:0]       tx, ty, tz;
  logic signed [QT-1:0]       n_wtx, n_wty, n_wtz;
  logic signed [QT-1:0]       n_ytz, n_zty, n_ztx, n_xtz, n_xty, n_ytx;
  logic        [CD:0]         cx, cy, cz;
  logic        [EW-1:0]       ex, ey, ez;

  assign end_s    = !dn_valid || dn_ready;
  assign enc      = !vc || end_s;
  assign enb      = !vb || enc;
  assign ena      = !va || enb;
  assign up_ready = ena;

  // rounded cross product q x s
  assign cx = (CD+1)'(m_ysz) - (CD+1)'(m_zsy) + (CD+1)'(qst_pkg::QUAT_HALF);
  assign cy = (CD+1)'(m_zsx) - (CD+1)'(m_xsz) + (CD+1)'(qst_pkg::QUAT_HALF);
  assign cz = (CD+1)'(m_xsy) - (CD+1)'(m_ysx) + (CD+1)'(qst_pkg::QUAT_HALF);

  // w*t + q x t, plus rounding half
  assign ex = EW'(n_wtx) + EW'(n_ytz) - EW'(n_zty) + EW'(qst_pkg::QUAT_HALF);
  assign ey = EW'(n_wty) + EW'(n_ztx) - EW'(n_xtz) + EW'(qst_pkg::QUAT_HALF);
  assign ez = EW'(n_wtz) + EW'(n_xty) - EW'(n_ytx) + EW'(qst_pkg::QUAT_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (ena) va <= up_valid;
      if (enb) vb <= va;
      if (enc) vc <= vb;
      if (end_s) dn_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      sa    <= up_data;
      m_ysz <= QS'(cfg.qy) * QS'(up_data.z);
      m_zsy <= QS'(cfg.qz) * QS'(up_data.y);
      m_zsx <= QS'(cfg.qz) * QS'(up_data.x);
      m_xsz <= QS'(cfg.qx) * QS'(up_data.z);
      m_xsy <= QS'(cfg.qx) * QS'(up_data.y);
      m_ysx <= QS'(cfg.qy) * QS'(up_data.x);
    end
    if (enb) begin
      sb <= sa;
      tx <= $signed({cx[CD:FR], 1'b0});
      ty <= $signed({cy[CD:FR], 1'b0});
      tz <= $signed({cz[CD:FR], 1'b0});
    end
    if (enc) begin
      sc    <= sb;
      n_wtx <= QT'(cfg.qw) * QT'(tx);
      n_wty <= QT'(cfg.qw) * QT'(ty);
      n_wtz <= QT'(cfg.qw) * QT'(tz);
      n_ytz <= QT'(cfg.qy) * QT'(tz);
      n_zty <= QT'(cfg.qz) * QT'(ty);
      n_ztx <= QT'(cfg.qz) * QT'(tx);
      n_xtz <= QT'(cfg.qx) * QT'(tz);
      n_xty <= QT'(cfg.qx) * QT'(ty);
      n_ytx <= QT'(cfg.qy) * QT'(tx);
    end
    if (end_s) begin
      dn_data.op <= sc.op;
      dn_data.x  <= RW'(sc.x) + RW'($signed(ex[EW-1:FR]));
      dn_data.y  <= RW'(sc.y) + RW'($signed(ey[EW-1:FR]));
      dn_data.z  <= RW'(sc.z) + RW'($signed(ez[EW-1:FR]));
    end
  end
endmodule

>>> src/qst_place.sv
// translation, saturation and output register
module qst_place (
  input  logic              clk,
  input  logic              rst,
  input  qst_pkg::cfg_t     cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  qst_pkg::rotated_t up_data,
  qst_out_if.source         dn
);
  localparam int FW = qst_pkg::F_W;
  localparam int CW = qst_pkg::COORD_W;

  logic signed [FW-1:0] fx, fy, fz;
  logic                 ovx, ovy, ovz;
  logic                 en;

  function automatic logic signed [CW-1:0] clamp(input logic signed [FW-1:0] v);
    logic signed [CW-1:0] res;
    if (v > FW'($signed({1'b0, {(CW-1){1'b1}}}))) begin
      res = {1'b0, {(CW-1){1'b1}}};
    end else if (v < FW'($signed({1'b1, {(CW-1){1'b0}}}))) begin
      res = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

  function automatic logic over(input logic signed [FW-1:0] v);
    return (v[FW-1:CW-1] != '0) && (v[FW-1:CW-1] != '1);
  endfunction

  assign en       = !dn.valid || dn.ready;
  assign up_ready = en;

  // positions get the translation, directions do not
  assign fx = FW'(up_data.x) + (up_data.op ? FW'(0) : FW'(cfg.tx));
  assign fy = FW'(up_data.y) + (up_data.op ? FW'(0) : FW'(cfg.ty));
  assign fz = FW'(up_data.z) + (up_data.op ? FW'(0) : FW'(cfg.tz));

  assign ovx = over(fx);
  assign ovy = over(fy);
  assign ovz = over(fz);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn.valid <= 1'b0;
    end else if (en) begin
      dn.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn.out_x     <= clamp(fx);
      dn.out_y     <= clamp(fy);
      dn.out_z     <= clamp(fz);
      dn.saturated <= ovx || ovy || ovz;
    end
  end
endmodule
